@@ rtl/shcu_pkg.sv @@
// Package: types, constants and functions shared by the SHA-256 unit.
package shcu_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitReset [NumWords] = '{
    32'hcbbb9d5d, 32'h629a292a, 32'h9159015a, 32'h152fecd8,
    32'h67332667, 32'h8eb44a87, 32'hdb0c2e0d, 32'h47b5481d
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef logic [31:0] word_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;     // copy chain words into working words
    logic       round;    // run one round
    logic [5:0] rnd;      // round index
    logic       fold;     // add working words into chain words
  } rnd_ctrl_t;

  function automatic word_t rotr(word_t x, int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

endpackage

@@ rtl/shcu_if.sv @@
// Valid/ready channel interface carrying one payload.
interface shcu_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/shcu_round.sv @@
// Round unit: working words, chain words and one SHA-256 round per cycle while ctrl_i.round is set.
module shcu_round
  import shcu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rnd_ctrl_t ctrl_i,
  input  word_t     w_i,
  input  logic      chain_ld_i,   // load chain words from init words
  input  word_t     init_i [NumWords],
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  word_t     cfg_val_i,
  output word_t     chain_o [NumWords]
);
  word_t v_q [NumWords];
  word_t h_q [NumWords];
  word_t s0, s1, maj, ch, t1, t2;

  // Round function on the current working words.
  always_comb begin
    s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1 + ch + RoundK[ctrl_i.rnd] + w_i;
    t2  = s0 + maj;
  end

  // Working words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) v_q[i] <= '0;
    end else if (ctrl_i.load) begin
      v_q <= h_q;
    end else if (ctrl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Chain words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= InitReset;
    end else if (chain_ld_i) begin
      h_q <= init_i;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < NumWords; i++) h_q[i] <= h_q[i] + v_q[i];
    end else if (cfg_we_i) begin
      h_q[cfg_idx_i] <= cfg_val_i;
    end
  end

  assign chain_o = h_q;
endmodule

@@ rtl/shcu_sched.sv @@
// Message schedule: 16-word window, byte packing and in-place expansion.
module shcu_sched
  import shcu_pkg::*;
(
  input  logic       clk_i,
  input  logic       put_i,      // write one byte
  input  logic [5:0] pos_i,      // byte position in block
  input  logic [7:0] byte_i,
  input  logic       shift_i,    // advance window one word
  input  logic       clear_i,    // zero window after a block
  output word_t      w_o          // word for the current round
);
  word_t win_q [16];
  word_t x, y, s0, s1, nw;

  always_comb begin
    x  = win_q[1];
    y  = win_q[14];
    s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
    nw = win_q[0] + s0 + win_q[9] + s1;
  end

  // Window: bytes packed big-endian, then shifted one word per round.
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      for (int i = 0; i < 16; i++) win_q[i] <= '0;
    end else if (shift_i) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= nw;
    end else if (put_i) begin
      win_q[pos_i[5:2]][(3 - pos_i[1:0]) * 8 +: 8] <= byte_i;
    end
  end

  assign w_o = win_q[0];
endmodule

@@ rtl/sha256_hash_custom_iv_unit.sv @@
// Top level: SHA-256 hasher with configurable initial hash words.
//
// Channel  Dir  Payload
// in_if    in   data_byte[8], no_data, end_of_message
// out_if   out  digest_word[32], word_number[3], final_word
// apb      in   init_word_0..7 at byte addresses 0x00..0x1c
//
// A byte item is written into the message window; the item that fills a block
// then adds one load step, 64 rounds of the shared round unit and one fold step.
// Finishing pads byte by byte plus one or two
// blocks, then offers the 8 digest words one per cycle as out_if takes them.
// rst_ni clears control state; chain words reset to the default init set.
// in_if.ready is low while a block or the finish sequence runs.
module sha256_hash_custom_iv_unit
  import shcu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  shcu_if.sink               in_if,
  shcu_if.source             out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLoad  = 7'b0000010,
    StRound = 7'b0000100,
    StFold  = 7'b0001000,
    StPad   = 7'b0010000,
    StLen   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e      st_q, st_d;
  word_t       init_q [NumWords];
  word_t       chain [NumWords];
  word_t       w;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;       // finishing the message
  logic        lenblk_q, lenblk_d; // 0x80 pad byte already written
  logic        lendone_q, lendone_d; // length field written
  logic [2:0]  oidx_q, oidx_d;
  logic        put;
  logic [7:0]  put_byte;
  logic        chain_ld;
  logic        cfg_we;
  rnd_ctrl_t   ctrl;
  logic [63:0] bits;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[AddrW-1:2] < NumRegs);
  assign prdata = (paddr[AddrW-1:2] < NumRegs) ? init_q[paddr[4:2]] : '0;

  // Init word registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= InitReset;
    end else if (cfg_we) begin
      init_q[paddr[4:2]] <= pwdata;
    end
  end

  assign bits = {len_q, 3'b000};

  // Sequencer.
  always_comb begin
    st_d     = st_q;
    fill_d   = fill_q;
    len_d    = len_q;
    rnd_d    = rnd_q;
    fin_d    = fin_q;
    lenblk_d = lenblk_q;
    oidx_d   = oidx_q;
    put      = 1'b0;
    put_byte = in_if.data.data_byte;
    chain_ld = 1'b0;
    ctrl     = '0;
    ctrl.rnd = rnd_q;
    in_if.ready = (st_q == StIdle);
    case (st_q)
      StIdle: begin
        if (in_if.valid) begin
          if (!in_if.data.no_data) begin
            put    = 1'b1;
            fill_d = fill_q + 6'd1;
            len_d  = len_q + 61'd1;
          end
          fin_d = in_if.data.end_of_message;
          if (!in_if.data.no_data && fill_q == 6'd63) st_d = StLoad;
          else if (in_if.data.end_of_message) st_d = StPad;
        end
      end
      StPad: begin
        // First pad byte is 0x80, then zeros up to the length field.
        put      = 1'b1;
        put_byte = lenblk_q ? 8'h00 : PadByte;
        lenblk_d = 1'b1;
        fill_d   = fill_q + 6'd1;
        if (fill_q == 6'd63) st_d = StLoad;
        else if (fill_q == 6'd55) st_d = StLen;
      end
      StLen: begin
        put      = 1'b1;
        put_byte = bits[8 * (7 - fill_q[2:0]) +: 8];
        fill_d   = fill_q + 6'd1;
        if (fill_q == 6'd63) st_d = StLoad;
      end
      StLoad: begin
        ctrl.load = 1'b1;
        rnd_d     = '0;
        st_d      = StRound;
      end
      StRound: begin
        ctrl.round = 1'b1;
        rnd_d      = rnd_q + 6'd1;
        if (rnd_q == 6'd63) st_d = StFold;
      end
      StFold: begin
        ctrl.fold = 1'b1;
        if (!fin_q) st_d = StIdle;
        else if (lendone_q) st_d = StOut;
        else st_d = StPad;
      end
      StOut: begin
        if (out_if.ready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            st_d     = StIdle;
            chain_ld = 1'b1;
            fill_d   = '0;
            len_d    = '0;
            fin_d    = 1'b0;
            lenblk_d = 1'b0;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // Length block done flag: set when the length field was written.
  always_comb begin
    lendone_d = lendone_q;
    if (st_q == StLen) lendone_d = 1'b1;
    if (st_q == StOut && out_if.ready && oidx_q == 3'd7) lendone_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      fill_q    <= '0;
      len_q     <= '0;
      rnd_q     <= '0;
      fin_q     <= 1'b0;
      lenblk_q  <= 1'b0;
      lendone_q <= 1'b0;
      oidx_q    <= '0;
    end else begin
      st_q      <= st_d;
      fill_q    <= fill_d;
      len_q     <= len_d;
      rnd_q     <= rnd_d;
      fin_q     <= fin_d;
      lenblk_q  <= lenblk_d;
      lendone_q <= lendone_d;
      oidx_q    <= oidx_d;
    end
  end

  shcu_sched u_sched (
    .clk_i   (clk_i),
    .put_i   (put),
    .pos_i   (fill_q),
    .byte_i  (put_byte),
    .shift_i (ctrl.round),
    .clear_i (ctrl.fold),
    .w_o     (w)
  );

  shcu_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .w_i        (w),
    .chain_ld_i (chain_ld),
    .init_i     (init_q),
    .cfg_we_i   (cfg_we && len_q == '0 && fill_q == '0 && st_q == StIdle),
    .cfg_idx_i  (paddr[4:2]),
    .cfg_val_i  (pwdata),
    .chain_o    (chain)
  );

  // Digest output.
  assign out_if.valid                  = (st_q == StOut);
  assign out_if.data.digest_word       = chain[oidx_q];
  assign out_if.data.word_number       = oidx_q;
  assign out_if.data.final_word        = (oidx_q == 3'd7);
endmodule
